/* rtl/vgus_pkg.sv */
// ----------------------------------------------------------------------------
// vgus_pkg
// Shared codes, widths and helpers of the utterance segmenter.
// ----------------------------------------------------------------------------
package vgus_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ANGLE_W    = 16;
    localparam int RIDX_W     = 17;
    localparam int LEN_W      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int SIL_W      = 21;
    localparam int FRAMES_W   = 16;

    localparam logic [SIL_W-1:0]    SILENCE_MAX = {SIL_W{1'b1}};
    localparam logic [FRAMES_W-1:0] FRAMES_MAX  = {FRAMES_W{1'b1}};

    typedef logic [1:0] event_t;
    localparam event_t EV_FRAME   = 2'd0;
    localparam event_t EV_PUBLISH = 2'd1;
    localparam event_t EV_DISCARD = 2'd2;
    localparam event_t EV_READ    = 2'd3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_TAKE_MODE = 3'd0;
    localparam cfg_idx_t CFG_PRE_ROLL  = 3'd1;
    localparam cfg_idx_t CFG_HANG      = 3'd2;
    localparam cfg_idx_t CFG_MIN       = 3'd3;
    localparam cfg_idx_t CFG_MAX       = 3'd4;

    localparam logic [1:0] TAKE_LEFT  = 2'd0;
    localparam logic [1:0] TAKE_RIGHT = 2'd1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Mono pick; mean rounds toward zero
    function automatic sample_t mono_sample(input logic [1:0] mode,
                                           input sample_t l, input sample_t r);
        logic signed [SAMPLE_W:0] sum;
        logic signed [SAMPLE_W:0] adj;
        sum = {l[SAMPLE_W-1], l} + {r[SAMPLE_W-1], r};
        adj = sum + ((sum[SAMPLE_W] & sum[0]) ? 17'sd1 : 17'sd0);
        unique case (mode)
            TAKE_LEFT:  mono_sample = l;
            TAKE_RIGHT: mono_sample = r;
            default:    mono_sample = adj[SAMPLE_W:1];
        endcase
    endfunction

endpackage

/* rtl/vgus_if.sv */
// ----------------------------------------------------------------------------
// vgus_if
// Valid/ready channels of the utterance segmenter.
// ----------------------------------------------------------------------------
interface vgus_item_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic signed [vgus_pkg::SAMPLE_W-1:0] left_sample;
    logic signed [vgus_pkg::SAMPLE_W-1:0] right_sample;
    logic                           speech;
    logic [vgus_pkg::ANGLE_W-1:0]   angle_code;
    logic                           period_end;
    logic [vgus_pkg::RIDX_W-1:0]    read_index;
    modport source (output valid, operation, left_sample, right_sample, speech,
                    angle_code, period_end, read_index, input ready);
    modport sink (input valid, operation, left_sample, right_sample, speech,
                  angle_code, period_end, read_index, output ready);
endinterface

interface vgus_result_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     event_res;
    logic [vgus_pkg::LEN_W-1:0]     utt_length;
    logic                           clipped;
    logic [vgus_pkg::ANGLE_W-1:0]   utt_angle;
    logic signed [vgus_pkg::SAMPLE_W-1:0] read_sample;
    logic                           is_open;
    modport source (output valid, event_res, utt_length, clipped, utt_angle,
                    read_sample, is_open, input ready);
    modport sink (input valid, event_res, utt_length, clipped, utt_angle,
                  read_sample, is_open, output ready);
endinterface

interface vgus_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [vgus_pkg::CFG_IDX_W-1:0]  index;
    logic [vgus_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/vgus_ram.sv */
// ----------------------------------------------------------------------------
// vgus_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module vgus_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

/* rtl/vad_gated_utterance_segmenter.sv */
// Sequence: plain frame S_FRAME, S_EMIT; read S_RD, S_RWAIT, S_EMIT; frame
//   ending a period while capturing S_FRAME, S_SIL, S_CLOSE, S_EMIT; opening
//   frame S_FRAME, S_OPEN, S_DRD/S_DWR per pre-roll sample copied (min of stored
//   pre-roll and cap), S_EMIT. One item at a time; the next is accepted in the
//   cycle after the result loads the output register, which waits on res.ready.
// Reset: control state clears asynchronously; memories hold no reset value.
// ----------------------------------------------------------------------------
// vad_gated_utterance_segmenter
// Pre-roll ring and utterance store driven by a voice-activity flag.
// ----------------------------------------------------------------------------
module vad_gated_utterance_segmenter #(
    parameter int PRE_DEPTH = 8192,
    parameter int UTT_DEPTH = 131072
) (
    input  logic          clk,
    input  logic          rst_n,
    vgus_item_if.sink     item,
    vgus_result_if.source res,
    vgus_cfg_if.sink      cfg
);
    localparam int PAW = $clog2(PRE_DEPTH);
    localparam int PCW = $clog2(PRE_DEPTH + 1);
    localparam int UAW = $clog2(UTT_DEPTH);
    localparam int UCW = $clog2(UTT_DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FRAME = 4'd1;
    localparam logic [3:0] S_OPEN  = 4'd2;
    localparam logic [3:0] S_DRD   = 4'd3;
    localparam logic [3:0] S_DWR   = 4'd4;
    localparam logic [3:0] S_SIL   = 4'd5;
    localparam logic [3:0] S_CLOSE = 4'd6;
    localparam logic [3:0] S_RD    = 4'd7;
    localparam logic [3:0] S_RWAIT = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0] state_reg;

    // configuration
    logic [1:0]  take_mode_reg;
    logic [13:0] pre_roll_reg;
    logic [19:0] hang_reg;
    logic [17:0] min_reg;
    logic [17:0] max_reg;

    // latched item
    vgus_pkg::sample_t               left_reg;
    vgus_pkg::sample_t               right_reg;
    logic                            speech_reg;
    logic [vgus_pkg::ANGLE_W-1:0]    angle_reg;
    logic                            pend_reg;
    logic [UAW-1:0]                  ridx_reg;
    logic                            rd_ok_reg;

    // block state
    logic [PAW-1:0]                  wpos_reg;
    logic [PCW-1:0]                  pre_count_reg;
    logic [UCW-1:0]                  utt_count_reg;
    logic [vgus_pkg::SIL_W-1:0]      sil_reg;
    logic                            capturing_reg;
    logic [vgus_pkg::ANGLE_W-1:0]    held_angle_reg;
    logic [vgus_pkg::FRAMES_W-1:0]   pf_reg;
    logic [PAW-1:0]                  rptr_reg;
    logic [UCW-1:0]                  dlim_reg;

    // staged result
    vgus_pkg::event_t                ev_reg;
    logic [UCW-1:0]                  len_reg;
    logic                            clip_reg;
    logic [vgus_pkg::ANGLE_W-1:0]    ang_reg;
    vgus_pkg::sample_t               rd_reg;

    // output register
    logic                            res_valid_reg;
    vgus_pkg::event_t                out_ev_reg;
    logic [vgus_pkg::LEN_W-1:0]      out_len_reg;
    logic                            out_clip_reg;
    logic [vgus_pkg::ANGLE_W-1:0]    out_ang_reg;
    vgus_pkg::sample_t               out_rd_reg;
    logic                            out_open_reg;

    logic [PCW-1:0] cap_pre;
    logic [UCW-1:0] cap_utt;
    vgus_pkg::sample_t sample;
    logic [PAW-1:0] pre_addr;
    logic [PCW-1:0] pre_addr_inc;
    logic [PCW-1:0] rptr_inc;
    logic [PCW-1:0] pc_clamp;
    logic [31:0]    start_sum;
    logic [31:0]    start_pos;
    logic [31:0]    dlim_calc;
    logic [vgus_pkg::SIL_W:0] sil_sum;
    logic           close_hit;
    logic           at_cap;
    logic           publish;
    logic           load_out;

    logic                          pre_we;
    logic                          pre_re;
    logic [vgus_pkg::SAMPLE_W-1:0] pre_rdata;
    logic                          utt_we;
    logic                          utt_re;
    logic [UAW-1:0]                utt_waddr;
    logic [vgus_pkg::SAMPLE_W-1:0] utt_wdata;
    logic [vgus_pkg::SAMPLE_W-1:0] utt_rdata;

    assign cap_pre = (32'(pre_roll_reg) > 32'(PRE_DEPTH)) ? PCW'(PRE_DEPTH)
                                                          : PCW'(pre_roll_reg);
    assign cap_utt = (32'(max_reg) > 32'(UTT_DEPTH)) ? UCW'(UTT_DEPTH)
                                                     : UCW'(max_reg);
    assign sample  = vgus_pkg::mono_sample(take_mode_reg, left_reg, right_reg);

    assign pre_addr     = (PCW'(wpos_reg) >= cap_pre) ? '0 : wpos_reg;
    assign pre_addr_inc = PCW'(pre_addr) + PCW'(1);
    assign rptr_inc     = PCW'(rptr_reg) + PCW'(1);

    assign pc_clamp  = (pre_count_reg > cap_pre) ? cap_pre : pre_count_reg;
    assign start_sum = 32'(wpos_reg) + 32'(cap_pre) - 32'(pc_clamp);
    assign start_pos = (start_sum >= 32'(cap_pre)) ? start_sum - 32'(cap_pre)
                                                   : start_sum;
    assign dlim_calc = (32'(pc_clamp) < 32'(cap_utt)) ? 32'(pc_clamp)
                                                      : 32'(cap_utt);

    assign sil_sum = {1'b0, sil_reg} + (vgus_pkg::SIL_W + 1)'(pf_reg);

    assign at_cap    = utt_count_reg >= cap_utt;
    assign close_hit = (sil_reg >= vgus_pkg::SIL_W'(hang_reg)) || at_cap;
    assign publish   = (32'(utt_count_reg) > 32'(sil_reg)) &&
                       ((32'(utt_count_reg) - 32'(sil_reg)) >= 32'(min_reg));

    assign load_out  = (state_reg == S_EMIT) && (!res_valid_reg || res.ready);

    always_comb
    begin
        pre_we    = 1'b0;
        pre_re    = 1'b0;
        utt_we    = 1'b0;
        utt_re    = 1'b0;
        utt_waddr = utt_count_reg[UAW-1:0];
        utt_wdata = sample;
        unique case (state_reg)
            S_FRAME:
            begin
                pre_we = !capturing_reg && (cap_pre != '0);
                utt_we = capturing_reg && (utt_count_reg < cap_utt);
            end
            S_DRD:
            begin
                pre_re = utt_count_reg < dlim_reg;
            end
            S_DWR:
            begin
                utt_we    = 1'b1;
                utt_wdata = pre_rdata;
            end
            S_RD:
            begin
                utt_re = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    vgus_ram #(.DEPTH(PRE_DEPTH), .WIDTH(vgus_pkg::SAMPLE_W)) u_pre_ram (
        .clk     (clk),
        .wr_en   (pre_we),
        .wr_addr (pre_addr),
        .wr_data (sample),
        .rd_en   (pre_re),
        .rd_addr (rptr_reg),
        .rd_data (pre_rdata)
    );

    vgus_ram #(.DEPTH(UTT_DEPTH), .WIDTH(vgus_pkg::SAMPLE_W)) u_utt_ram (
        .clk     (clk),
        .wr_en   (utt_we),
        .wr_addr (utt_waddr),
        .wr_data (utt_wdata),
        .rd_en   (utt_re),
        .rd_addr (ridx_reg),
        .rd_data (utt_rdata)
    );

    assign item.ready = state_reg == S_IDLE;
    assign cfg.ready  = 1'b1;

    assign res.valid       = res_valid_reg;
    assign res.event_res   = out_ev_reg;
    assign res.utt_length  = out_len_reg;
    assign res.clipped     = out_clip_reg;
    assign res.utt_angle   = out_ang_reg;
    assign res.read_sample = out_rd_reg;
    assign res.is_open     = out_open_reg;

    // payload latches
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            left_reg   <= item.left_sample;
            right_reg  <= item.right_sample;
            speech_reg <= item.speech;
            angle_reg  <= item.angle_code;
            pend_reg   <= item.period_end;
            ridx_reg   <= UAW'(32'(item.read_index));
            rd_ok_reg  <= 32'(item.read_index) < 32'(UTT_DEPTH);
        end
        if (load_out)
        begin
            out_ev_reg   <= ev_reg;
            out_len_reg  <= vgus_pkg::LEN_W'(len_reg);
            out_clip_reg <= clip_reg;
            out_ang_reg  <= ang_reg;
            out_rd_reg   <= rd_reg;
            out_open_reg <= capturing_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            take_mode_reg  <= 2'd0;
            pre_roll_reg   <= 14'd4096;
            hang_reg       <= 20'd12800;
            min_reg        <= 18'd4800;
            max_reg        <= 18'd131072;
            wpos_reg       <= '0;
            pre_count_reg  <= '0;
            utt_count_reg  <= '0;
            sil_reg        <= '0;
            capturing_reg  <= 1'b0;
            held_angle_reg <= '0;
            pf_reg         <= '0;
            rptr_reg       <= '0;
            dlim_reg       <= '0;
            ev_reg         <= vgus_pkg::EV_FRAME;
            len_reg        <= '0;
            clip_reg       <= 1'b0;
            ang_reg        <= '0;
            rd_reg         <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item.valid)
                    begin
                        ev_reg   <= item.operation ? vgus_pkg::EV_READ
                                                   : vgus_pkg::EV_FRAME;
                        len_reg  <= '0;
                        clip_reg <= 1'b0;
                        ang_reg  <= '0;
                        rd_reg   <= '0;
                        state_reg <= item.operation ? S_RD : S_FRAME;
                    end
                end
                S_FRAME:
                begin
                    if (!capturing_reg)
                    begin
                        if (cap_pre != '0)
                        begin
                            wpos_reg <= (pre_addr_inc == cap_pre) ? '0
                                                                  : PAW'(pre_addr_inc);
                            if (pre_count_reg < cap_pre)
                            begin
                                pre_count_reg <= pre_count_reg + PCW'(1);
                            end
                        end
                    end
                    else if (utt_count_reg < cap_utt)
                    begin
                        utt_count_reg <= utt_count_reg + UCW'(1);
                    end
                    // a silent period end while idle just restarts the frame count
                    if (pend_reg && !capturing_reg && !speech_reg)
                    begin
                        pf_reg <= '0;
                    end
                    else if (pf_reg != vgus_pkg::FRAMES_MAX)
                    begin
                        pf_reg <= pf_reg + 16'd1;
                    end
                    priority if (!pend_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else if (!capturing_reg && speech_reg)
                    begin
                        state_reg <= S_OPEN;
                    end
                    else if (capturing_reg)
                    begin
                        state_reg <= S_SIL;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_OPEN:
                begin
                    rptr_reg       <= PAW'(start_pos);
                    dlim_reg       <= UCW'(dlim_calc);
                    held_angle_reg <= angle_reg;
                    utt_count_reg  <= '0;
                    pre_count_reg  <= '0;
                    wpos_reg       <= '0;
                    sil_reg        <= '0;
                    capturing_reg  <= 1'b1;
                    pf_reg         <= '0;
                    state_reg      <= S_DRD;
                end
                S_DRD:
                begin
                    if (utt_count_reg < dlim_reg)
                    begin
                        rptr_reg  <= (rptr_inc == cap_pre) ? '0 : PAW'(rptr_inc);
                        state_reg <= S_DWR;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_DWR:
                begin
                    utt_count_reg <= utt_count_reg + UCW'(1);
                    state_reg     <= S_DRD;
                end
                S_SIL:
                begin
                    if (speech_reg)
                    begin
                        sil_reg <= '0;
                    end
                    else if (sil_sum[vgus_pkg::SIL_W])
                    begin
                        sil_reg <= vgus_pkg::SILENCE_MAX;
                    end
                    else
                    begin
                        sil_reg <= sil_sum[vgus_pkg::SIL_W-1:0];
                    end
                    pf_reg    <= '0;
                    state_reg <= S_CLOSE;
                end
                S_CLOSE:
                begin
                    if (close_hit)
                    begin
                        ev_reg        <= publish ? vgus_pkg::EV_PUBLISH
                                                 : vgus_pkg::EV_DISCARD;
                        len_reg       <= utt_count_reg;
                        clip_reg      <= at_cap;
                        ang_reg       <= held_angle_reg;
                        capturing_reg <= 1'b0;
                        utt_count_reg <= '0;
                        sil_reg       <= '0;
                    end
                    state_reg <= S_EMIT;
                end
                S_RD:
                begin
                    state_reg <= S_RWAIT;
                end
                S_RWAIT:
                begin
                    rd_reg    <= rd_ok_reg ? vgus_pkg::sample_t'(utt_rdata) : '0;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // the user must send register writes only while idle; the block leaves this to the user
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    vgus_pkg::CFG_TAKE_MODE: take_mode_reg <= cfg.data[1:0];
                    vgus_pkg::CFG_PRE_ROLL:
                    begin
                        pre_roll_reg  <= cfg.data[13:0];
                        wpos_reg      <= '0;
                        pre_count_reg <= '0;
                    end
                    vgus_pkg::CFG_HANG:      hang_reg <= cfg.data[19:0];
                    vgus_pkg::CFG_MIN:       min_reg  <= cfg.data[17:0];
                    vgus_pkg::CFG_MAX:       max_reg  <= cfg.data[17:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("input accepted twice without result");

    a_drain_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRD && utt_count_reg < dlim_reg) |=> state_reg == S_DWR)
        else $error("drain read not followed by store write");

    a_pre_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pre_count_reg <= cap_pre)
        else $error("pre-roll count above ring length");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !capturing_reg |-> (utt_count_reg == '0 && sil_reg == '0))
        else $error("utterance counters live while idle");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the utterance segmenter: drives frames and reads
// over valid/ready channels, predicts every result with its own model of the
// pre-roll ring, utterance store and close logic, and compares in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int PRE_D      = 8192;
    localparam int UTT_D      = 131072;
    localparam int WD_LIMIT   = 100000;
    localparam int TAIL_WAIT  = 20;
    localparam int N_PHASES   = 8;
    localparam int PHASE_LEN  = 100;

    typedef struct {
        logic                          op;
        vgus_pkg::sample_t             l;
        vgus_pkg::sample_t             r;
        logic                          speech;
        logic [vgus_pkg::ANGLE_W-1:0]  angle;
        logic                          pend;
        logic [vgus_pkg::RIDX_W-1:0]   ridx;
    } seg_item_t;

    typedef struct {
        vgus_pkg::event_t              ev;
        logic [vgus_pkg::LEN_W-1:0]    len;
        logic                          clip;
        logic [vgus_pkg::ANGLE_W-1:0]  angle;
        vgus_pkg::sample_t             rd;
        logic                          is_open;
    } seg_result_t;

    logic clk;
    logic rst_n;

    vgus_item_if   item_if ();
    vgus_result_if res_if ();
    vgus_cfg_if    cfg_if ();

    vad_gated_utterance_segmenter i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    // Model state
    logic [15:0]  pre_mem [PRE_D];
    logic [15:0]  utt_mem [UTT_D];
    int unsigned  wr_pos, pre_cnt, utt_cnt, sil_cnt, frames_cnt;
    int unsigned  pre_len, hang_len, min_len, cap_len;
    logic [1:0]   mode_q;
    bit           open_q;
    logic [15:0]  angle_q;
    int unsigned  utt_written;

    seg_result_t  pending_q [$];
    int           mismatches;
    int           wd_count;
    bit           no_idle;
    int           rem_in_period;
    bit           period_speech;
    int           res_stall;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int gap_len();
        int p;
        if (no_idle)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic predict_result(input seg_item_t it);
        seg_result_t e;
        int          s, n, start;
        logic [15:0] su;
        bit          clip;
        int unsigned cp, cu;
        cp = (pre_len > PRE_D) ? PRE_D : pre_len;
        cu = (cap_len > UTT_D) ? UTT_D : cap_len;
        e = '{ev: vgus_pkg::EV_FRAME, len: '0, clip: 1'b0, angle: '0, rd: '0,
              is_open: 1'b0};
        if (it.op)
        begin
            e.ev = vgus_pkg::EV_READ;
            e.rd = utt_mem[it.ridx];
        end
        else
        begin
            if (mode_q == vgus_pkg::TAKE_LEFT) s = it.l;
            else if (mode_q == vgus_pkg::TAKE_RIGHT) s = it.r;
            else s = (int'(it.l) + int'(it.r)) / 2;
            su = s[15:0];
            if (!open_q)
            begin
                if (cp > 0)
                begin
                    if (wr_pos >= cp) wr_pos = 0;
                    pre_mem[wr_pos] = su;
                    wr_pos = (wr_pos + 1) % cp;
                    if (pre_cnt < cp) pre_cnt++;
                end
            end
            else if (utt_cnt < cu)
            begin
                utt_mem[utt_cnt] = su;
                utt_cnt++;
                if (utt_cnt > utt_written) utt_written = utt_cnt;
            end
            if (frames_cnt < 65535) frames_cnt++;
            if (it.pend)
            begin
                if (!open_q && it.speech)
                begin
                    if (pre_cnt > cp) pre_cnt = cp;
                    start = (cp > 0) ? (wr_pos + cp - pre_cnt) % cp : 0;
                    angle_q = it.angle;
                    utt_cnt = 0;
                    for (n = 0; n < pre_cnt && utt_cnt < cu; n++)
                    begin
                        utt_mem[utt_cnt] = pre_mem[(start + n) % cp];
                        utt_cnt++;
                    end
                    if (utt_cnt > utt_written) utt_written = utt_cnt;
                    pre_cnt = 0;
                    wr_pos  = 0;
                    sil_cnt = 0;
                    open_q  = 1'b1;
                end
                else if (open_q)
                begin
                    if (it.speech)
                        sil_cnt = 0;
                    else
                    begin
                        sil_cnt += frames_cnt;
                        if (sil_cnt > vgus_pkg::SILENCE_MAX) sil_cnt = vgus_pkg::SILENCE_MAX;
                    end
                    if (sil_cnt >= hang_len || utt_cnt >= cu)
                    begin
                        clip = utt_cnt >= cu;
                        e.ev = (utt_cnt > sil_cnt && (utt_cnt - sil_cnt) >= min_len)
                               ? vgus_pkg::EV_PUBLISH : vgus_pkg::EV_DISCARD;
                        e.len   = vgus_pkg::LEN_W'(utt_cnt);
                        e.clip  = clip;
                        e.angle = angle_q;
                        open_q  = 1'b0;
                        utt_cnt = 0;
                        sil_cnt = 0;
                    end
                end
                frames_cnt = 0;
            end
        end
        e.is_open = open_q;
        pending_q.push_back(e);
    endtask

    task automatic send_item(input seg_item_t it);
        int g;
        g = gap_len();
        repeat (g)
        begin
            @(negedge clk);
            item_if.valid = 1'b0;
        end
        @(negedge clk);
        item_if.valid        = 1'b1;
        item_if.operation    = it.op;
        item_if.left_sample  = it.l;
        item_if.right_sample = it.r;
        item_if.speech       = it.speech;
        item_if.angle_code   = it.angle;
        item_if.period_end   = it.pend;
        item_if.read_index   = it.ridx;
        do
            @(posedge clk);
        while (!item_if.ready);
        predict_result(it);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_if.valid = 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input vgus_pkg::cfg_idx_t idx, input int unsigned value);
        wait_drained();
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value[vgus_pkg::CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            vgus_pkg::CFG_TAKE_MODE: mode_q = value[1:0];
            vgus_pkg::CFG_PRE_ROLL:
            begin
                pre_len = value & 32'h3FFF;
                wr_pos  = 0;
                pre_cnt = 0;
            end
            vgus_pkg::CFG_HANG: hang_len = value & 32'hFFFFF;
            vgus_pkg::CFG_MIN:  min_len  = value & 32'h3FFFF;
            vgus_pkg::CFG_MAX:  cap_len  = value & 32'h3FFFF;
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic send_frame(input int l, input int r, input bit sp, input bit pend);
        seg_item_t it;
        it = '{op: 1'b0, l: l[15:0], r: r[15:0], speech: sp,
               angle: vgus_pkg::ANGLE_W'($urandom()), pend: pend,
               ridx: vgus_pkg::RIDX_W'($urandom())};
        send_item(it);
    endtask

    task automatic send_read(input int unsigned idx);
        seg_item_t it;
        it = '{op: 1'b1, l: 16'($urandom()), r: 16'($urandom()),
               speech: 1'($urandom()), angle: vgus_pkg::ANGLE_W'($urandom()),
               pend: 1'($urandom()), ridx: idx[vgus_pkg::RIDX_W-1:0]};
        send_item(it);
    endtask

    task automatic test_take_modes();
        int m;
        write_reg(vgus_pkg::CFG_PRE_ROLL, 2);
        write_reg(vgus_pkg::CFG_HANG, 1);
        write_reg(vgus_pkg::CFG_MIN, 0);
        write_reg(vgus_pkg::CFG_MAX, 40);
        for (m = 0; m < 4; m++)
        begin
            write_reg(vgus_pkg::CFG_TAKE_MODE, m);
            send_frame(32767, -32768, 1'b0, 1'b0);
            send_frame(-1, -32768, 1'b1, 1'b1);
            send_frame(-32768, 32767, 1'b0, 1'b1);
            send_read(0);
            send_read(1);
        end
    endtask

    task automatic test_cap_edges();
        // zero cap: opens, stores nothing, closes clipped at next period end
        write_reg(vgus_pkg::CFG_MAX, 0);
        send_frame(5, 6, 1'b1, 1'b1);
        send_frame(7, 8, 1'b1, 1'b1);
        // cap and pre-roll beyond depth saturate
        write_reg(vgus_pkg::CFG_MAX, 262143);
        write_reg(vgus_pkg::CFG_PRE_ROLL, 16383);
        send_frame(100, -100, 1'b0, 1'b0);
        send_frame(-7, 3, 1'b1, 1'b1);
        send_frame(1, 1, 1'b0, 1'b1);
        // pre-roll longer than the cap: drain keeps the oldest
        write_reg(vgus_pkg::CFG_PRE_ROLL, 8);
        write_reg(vgus_pkg::CFG_MAX, 3);
        send_frame(11, 0, 1'b0, 1'b0);
        send_frame(12, 0, 1'b0, 1'b0);
        send_frame(13, 0, 1'b0, 1'b0);
        send_frame(14, 0, 1'b1, 1'b1);
        send_frame(15, 0, 1'b1, 1'b1);
        send_read(2);
        // zero pre-roll
        write_reg(vgus_pkg::CFG_PRE_ROLL, 0);
        write_reg(vgus_pkg::CFG_MAX, 131072);
        write_reg(vgus_pkg::CFG_MIN, 131072);
        send_frame(1, 2, 1'b1, 1'b1);
        send_frame(3, 4, 1'b0, 1'b1);
    endtask

    task automatic rand_config();
        int p;
        write_reg(vgus_pkg::CFG_TAKE_MODE, $urandom_range(0, 3));
        p = $urandom_range(0, 9);
        write_reg(vgus_pkg::CFG_PRE_ROLL,
                  (p == 0) ? 8192 : (p == 1) ? 16383 : $urandom_range(0, 12));
        p = $urandom_range(0, 9);
        write_reg(vgus_pkg::CFG_HANG,
                  (p == 0) ? 0 : (p == 1) ? 1048575 : $urandom_range(1, 30));
        p = $urandom_range(0, 9);
        write_reg(vgus_pkg::CFG_MIN,
                  (p == 0) ? 131072 : (p == 1) ? 0 : $urandom_range(1, 40));
        p = $urandom_range(0, 9);
        write_reg(vgus_pkg::CFG_MAX, (p == 0) ? 0 : (p == 1) ? 262143 : (p == 2) ? 1
                                                   : $urandom_range(2, 60));
    endtask

    function automatic int rand_sample();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return -32768;
        if (p == 1) return 32767;
        return $signed($urandom_range(0, 65535) - 32768);
    endfunction

    task automatic test_random_traffic();
        int  ph, k;
        bit  pend;
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            rand_config();
            no_idle = (ph == 2);
            rem_in_period = 0;
            for (k = 0; k < PHASE_LEN; k++)
            begin
                if (ph == 3 && k == PHASE_LEN / 2)
                    wait_drained();
                if (utt_written > 0 && $urandom_range(0, 9) == 0)
                    send_read($urandom_range(0, utt_written - 1));
                else
                begin
                    if (rem_in_period == 0)
                    begin
                        rem_in_period = $urandom_range(1, 5);
                        period_speech = 1'($urandom_range(0, 1));
                    end
                    pend = (rem_in_period == 1);
                    rem_in_period--;
                    // occasional broken period marks
                    if ($urandom_range(0, 24) == 0) pend = ~pend;
                    send_frame(rand_sample(), rand_sample(), period_speech, pend);
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Result side: random stalls, in-order compare
    always @(negedge clk)
    begin
        if (res_stall > 0)
        begin
            res_if.ready = 1'b0;
            res_stall--;
        end
        else
        begin
            res_if.ready = 1'b1;
            if (!no_idle) res_stall = gap_len();
        end
    end

    always @(posedge clk)
    begin
        seg_result_t e;
        if (res_if.valid && res_if.ready)
        begin
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction, event %0d",
                             res_if.event_res);
            end
            else
            begin
                e = pending_q.pop_front();
                if (res_if.event_res !== e.ev || res_if.utt_length !== e.len ||
                    res_if.clipped !== e.clip || res_if.utt_angle !== e.angle ||
                    res_if.read_sample !== e.rd || res_if.is_open !== e.is_open)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp ev=%0d len=%0d clip=%0d ang=%h rd=%0d",
                                  " open=%0d got ev=%0d len=%0d clip=%0d ang=%h",
                                  " rd=%0d open=%0d"},
                                 e.ev, e.len, e.clip, e.angle, e.rd, e.is_open,
                                 res_if.event_res, res_if.utt_length, res_if.clipped,
                                 res_if.utt_angle, res_if.read_sample, res_if.is_open);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready) || !rst_n)
            wd_count = 0;
        else
            wd_count++;
        if (wd_count >= WD_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.operation = 1'b0;
        item_if.left_sample = '0;
        item_if.right_sample = '0;
        item_if.speech = 1'b0;
        item_if.angle_code = '0;
        item_if.period_end = 1'b0;
        item_if.read_index = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        res_stall = 0;
        no_idle = 1'b0;
        mismatches = 0;
        wd_count = 0;
        wr_pos = 0; pre_cnt = 0; utt_cnt = 0; sil_cnt = 0; frames_cnt = 0;
        mode_q = 2'd0; pre_len = 4096; hang_len = 12800; min_len = 4800;
        cap_len = 131072; open_q = 1'b0; angle_q = '0; utt_written = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults after reset
        send_frame(-32768, 32767, 1'b0, 1'b0);
        send_frame(32767, -32768, 1'b1, 1'b0);
        test_take_modes();
        test_cap_edges();
        test_random_traffic();

        wait_drained();
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
